// ===== hdl/mshw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the heartbeat watchdog.
`default_nettype none

package mshw_pkg;

	// Table geometry
	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Input word modes
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_REG     = 2'd1;
	localparam logic [1:0] MODE_UNREG   = 2'd2;
	localparam logic [1:0] MODE_CONFIRM = 2'd3;

	// Result word kinds
	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_DEAD    = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;

	// Timing limits and reset values
	localparam logic [23:0] INTERVAL_RESET = 24'd1000;
	localparam logic [23:0] TIMEOUT_RESET  = 24'd5000;
	localparam logic [23:0] MIN_INTERVAL   = 24'd100;
	localparam logic [23:0] MIN_TIMEOUT    = 24'd500;
	localparam logic [24:0] TIMEOUT_MARGIN = 25'd200;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic read;
		logic step;
		logic finish;
	} mshw_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic more;
		logic need_emit;
		logic out_free;
	} mshw_status_t;

endpackage

`default_nettype wire

// ===== hdl/mshw_ctrl.sv =====
// Sequencing state machine of the heartbeat watchdog.
`default_nettype none

module mshw_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire mshw_pkg::mshw_status_t st,
	output mshw_pkg::mshw_cmd_t        cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One word at a time: take it, walk the table, then deliver the closing result.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.more) begin
					cmd.read = 1'b1;
					state_d  = ST_EVAL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EVAL: begin
				// A timed-out entry waits here until the output register is free.
				if (!st.need_emit || st.out_free) begin
					cmd.step = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");
`endif

endmodule

`default_nettype wire

// ===== hdl/mshw_dpath.sv =====
// Entry table, timing registers and result register of the heartbeat watchdog.
`default_nettype none

module mshw_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mshw_pkg::mshw_cmd_t           cmd,
	output mshw_pkg::mshw_status_t             st,
	input  wire logic [1:0]                    mode,
	input  wire logic [7:0]                    slot_id,
	input  wire logic [31:0]                   now_ms,
	input  wire logic                          cfg_valid,
	input  wire logic [mshw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [23:0]                   cfg_data,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [1:0]                         kind,
	output logic [7:0]                         dead_slot,
	output logic                               broadcast,
	output logic [4:0]                         killed_count,
	output logic                               table_full,
	output logic                               last
);

	localparam int IW = mshw_pkg::IDX_W;
	localparam int CW = mshw_pkg::CNT_W;

	// Entry memories
	logic [7:0]  id_mem [mshw_pkg::SLOTS];
	logic [31:0] lr_mem [mshw_pkg::SLOTS];
	logic [7:0]  rid_q;
	logic [31:0] rlr_q;

	// Item and scan registers
	logic [1:0]    mode_q;
	logic [7:0]    id_q;
	logic [31:0]   now_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          found_q;
	logic [4:0]    killed_q;
	logic          bc_q;
	logic [31:0]   lbt_q;

	// Timing registers
	logic [23:0] iv_raw_q;
	logic [23:0] to_raw_q;
	logic [24:0] eff_to_q;
	logic [23:0] eff_iv;
	logic [23:0] to_min;
	logic [24:0] to_eff_d;

	// Result register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  dead_q;
	logic        bc_out_q;
	logic [4:0]  killed_out_q;
	logic        full_q;
	logic        last_q;

	// Decision signals
	logic        is_tick;
	logic        aged;
	logic        match;
	logic        hit;
	logic        drop;
	logic        emit_kill;
	logic        has_room;
	logic        append;
	logic        full;
	logic        bc_now;
	logic        out_free;
	logic        mem_we;
	logic [IW-1:0] mem_wa;
	logic [7:0]  mem_wid;
	logic [31:0] mem_wlr;

	// Effective interval and timeout after clamping.
	always_comb begin
		eff_iv = (iv_raw_q < mshw_pkg::MIN_INTERVAL) ? mshw_pkg::MIN_INTERVAL : iv_raw_q;
		to_min = (to_raw_q < mshw_pkg::MIN_TIMEOUT) ? mshw_pkg::MIN_TIMEOUT : to_raw_q;
		if ({1'b0, to_min} <= {1'b0, eff_iv}) begin
			to_eff_d = {1'b0, eff_iv} + mshw_pkg::TIMEOUT_MARGIN;
		end else begin
			to_eff_d = {1'b0, to_min};
		end
	end

	// Configuration registers; the effective timeout is registered from the clamped raw values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_raw_q <= mshw_pkg::INTERVAL_RESET;
			to_raw_q <= mshw_pkg::TIMEOUT_RESET;
			eff_to_q <= {1'b0, mshw_pkg::TIMEOUT_RESET};
		end else begin
			if (cfg_valid && (cfg_index == mshw_pkg::CFG_INTERVAL)) begin
				iv_raw_q <= cfg_data;
			end
			if (cfg_valid && (cfg_index == mshw_pkg::CFG_TIMEOUT)) begin
				to_raw_q <= cfg_data;
			end
			eff_to_q <= to_eff_d;
		end
	end

	// Per-entry decisions on the word read from the table.
	always_comb begin
		is_tick   = (mode_q == mshw_pkg::MODE_TICK);
		aged      = ((now_q - rlr_q) > {7'd0, eff_to_q});
		match     = (rid_q == id_q);
		hit       = ((mode_q == mshw_pkg::MODE_REG) || (mode_q == mshw_pkg::MODE_CONFIRM))
			&& match && !found_q;
		drop      = is_tick ? aged : ((mode_q == mshw_pkg::MODE_UNREG) && match);
		emit_kill = cmd.step && is_tick && aged;
		has_room  = (wr_q < CW'(mshw_pkg::SLOTS));
		append    = (mode_q == mshw_pkg::MODE_REG) && !found_q && has_room;
		full      = (mode_q == mshw_pkg::MODE_REG) && !found_q && !has_room;
		bc_now    = ((now_ms - lbt_q) >= {8'd0, eff_iv});
		out_free  = !out_valid_q || !out_stall;
	end

	// Status to the controller.
	always_comb begin
		st.more      = (rd_q < count_q);
		st.need_emit = is_tick && aged;
		st.out_free  = out_free;
	end

	// Table write port: compaction copy during the scan, or append at the end.
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = wr_q[IW-1:0];
		mem_wid = rid_q;
		mem_wlr = hit ? now_q : rlr_q;
		if (cmd.step && !drop) begin
			mem_we = 1'b1;
		end else if (cmd.finish && append) begin
			mem_we  = 1'b1;
			mem_wid = id_q;
			mem_wlr = now_q;
		end
	end

	// Entry memories with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			id_mem[mem_wa] <= mem_wid;
			lr_mem[mem_wa] <= mem_wlr;
		end
		if (cmd.read) begin
			rid_q <= id_mem[rd_q[IW-1:0]];
			rlr_q <= lr_mem[rd_q[IW-1:0]];
		end
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= slot_id;
			now_q  <= now_ms;
		end
	end

	// Scan pointers, fill count, kill count and broadcast time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			found_q  <= 1'b0;
			killed_q <= '0;
			bc_q     <= 1'b0;
			lbt_q    <= '0;
		end else if (cmd.load) begin
			rd_q     <= '0;
			wr_q     <= '0;
			found_q  <= 1'b0;
			killed_q <= '0;
			bc_q     <= (mode == mshw_pkg::MODE_TICK) && bc_now;
			if ((mode == mshw_pkg::MODE_TICK) && bc_now) begin
				lbt_q <= now_ms;
			end
		end else if (cmd.step) begin
			rd_q <= rd_q + CW'(1);
			if (!drop) begin
				wr_q <= wr_q + CW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (emit_kill) begin
				killed_q <= killed_q + 5'd1;
			end
		end else if (cmd.finish) begin
			count_q <= wr_q + CW'(append);
		end
	end

	// Result register: loaded on an emission, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_kill || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_kill) begin
			kind_q       <= mshw_pkg::KIND_DEAD;
			dead_q       <= rid_q;
			bc_out_q     <= 1'b0;
			killed_out_q <= '0;
			full_q       <= 1'b0;
			last_q       <= 1'b0;
		end else if (cmd.finish) begin
			kind_q       <= is_tick ? mshw_pkg::KIND_SUMMARY : mshw_pkg::KIND_ACK;
			dead_q       <= '0;
			bc_out_q     <= bc_q;
			killed_out_q <= killed_q;
			full_q       <= full;
			last_q       <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign dead_slot    = dead_q;
	assign broadcast    = bc_out_q;
	assign killed_count = killed_out_q;
	assign table_full   = full_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(mshw_pkg::SLOTS))
		else $error("fill count beyond table depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q)
		else $error("compaction write pointer overtook read pointer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_kill || cmd.finish) |-> out_free)
		else $error("result register overwritten while still waiting");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (rd_q < count_q))
		else $error("table read beyond filled entries");
`endif

endmodule

`default_nettype wire

// ===== hdl/multi_slot_heartbeat_watchdog_core.sv =====
// Top level of the multi-slot heartbeat watchdog: controller and datapath.
`default_nettype none

// Watchdog over a table of up to SLOTS slots kept in registration order. Each input word is
// a tick, register, unregister or confirm; it gives one acknowledge, or for a tick one
// timed-out word per closed slot followed by a summary word carrying the broadcast flag and
// kill count. Words are handled one at a time: a new word is not taken until the last one is
// through, since every word walks the entry table one entry at a time (registered read, then
// decide and copy down), and waits while the output is stalled. The table needs no clearing
// after reset, as a fill count marks the valid entries. Configuration writes are always ready
// and take effect for the next word.
module multi_slot_heartbeat_watchdog_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     mode,
	input  wire logic [7:0]                     slot_id,
	input  wire logic [31:0]                    now_ms,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          kind,
	output logic [7:0]                          dead_slot,
	output logic                                broadcast,
	output logic [4:0]                          killed_count,
	output logic                                table_full,
	output logic                                last,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mshw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [23:0]                    cfg_data
);

	mshw_pkg::mshw_cmd_t    cmd;
	mshw_pkg::mshw_status_t st;

	// Register writes are never held off.
	assign cfg_ready = 1'b1;

	// Sequencer.
	mshw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Table and result datapath.
	mshw_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.mode         (mode),
		.slot_id      (slot_id),
		.now_ms       (now_ms),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.dead_slot    (dead_slot),
		.broadcast    (broadcast),
		.killed_count (killed_count),
		.table_full   (table_full),
		.last         (last)
	);

endmodule

`default_nettype wire
